>>> hw/rtl/bbkg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbkg_pkg
// Shared types and constants for the barometer bias Kalman gate.
// ----------------------------------------------------------------------------
package bbkg_pkg;

    localparam int unsigned Q_ONE           = 65536;
    localparam int unsigned ALPHA_Q         = 3277;   // 0.05
    localparam int unsigned ONE_MINUS_ALPHA = 62259;  // 1 - 0.05
    localparam int unsigned PAD_VAR_Q       = 32768;  // 0.5
    localparam int unsigned PROC_NOISE_Q    = 7;      // 1e-4
    localparam int unsigned NOISE_RST       = 65536;
    localparam int unsigned GATE_RST        = 1280;
    localparam int unsigned DIV_STEPS       = 32;

    // configuration register indexes
    localparam logic REG_NOISE = 1'b0;
    localparam logic REG_GATE  = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PAD_INIT,
        OP_EMA_M1,
        OP_EMA_M2,
        OP_EMA_ADD,
        OP_EMA_RND,
        OP_KF_PREP,
        OP_K_START,
        OP_K_ZERO,
        OP_K_WAIT,
        OP_KF_MUL,
        OP_KF_BIAS,
        OP_KF_VAR,
        OP_CORR,
        OP_INNOV,
        OP_G_SQ,
        OP_G_G2,
        OP_G_D,
        OP_G_START,
        OP_G_DZERO,
        OP_G_WAIT,
        OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic pad;
        logic gps_rej;
        logic bias_zero;
        logic s_zero;
        logic d_zero;
        logic div_done;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> hw/rtl/bbkg_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbkg_in_if
// Sample channel: one barometer word with flight context.
// ----------------------------------------------------------------------------
interface bbkg_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] baro_altitude;
    logic               on_pad;
    logic               gps_lost;
    logic signed [31:0] down_position;
    logic        [31:0] down_position_var;

    modport source (output valid, output baro_altitude, output on_pad, output gps_lost,
                    output down_position, output down_position_var, input ready);
    modport sink   (input valid, input baro_altitude, input on_pad, input gps_lost,
                    input down_position, input down_position_var, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bbkg_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbkg_out_if
// Result channel: corrected altitude, gate result and bias.
// ----------------------------------------------------------------------------
interface bbkg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] corrected_altitude;
    logic signed [31:0] innovation;
    logic        [31:0] gate_ratio;
    logic               rejected;
    logic               zero_position;
    logic signed [31:0] bias_out;

    modport source (output valid, output corrected_altitude, output innovation,
                    output gate_ratio, output rejected, output zero_position,
                    output bias_out, input ready);
    modport sink   (input valid, input corrected_altitude, input innovation,
                    input gate_ratio, input rejected, input zero_position,
                    input bias_out, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bbkg_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbkg_divider
// Restoring divider, one quotient bit per cycle, 32-bit quotient with
// overflow flag.
// ----------------------------------------------------------------------------
module bbkg_divider
    import bbkg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [78:0] i_dividend,
    input  logic [64:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic        o_sat
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [64:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_quot;
    logic [64:0] r_d;
    logic        r_sat;

    logic [65:0] trial;
    logic [66:0] diff;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_low[31]};
        diff  = {1'b0, trial} - {2'b0, r_d};
        ge    = ~diff[66];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quotient overflows 32 bits when the top part already reaches d
            r_rem <= {18'b0, i_dividend[78:32]};
            r_sat <= ({18'b0, i_dividend[78:32]} >= i_divisor);
            r_low <= i_dividend[31:0];
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[64:0] : trial[64:0];
            r_quot <= {r_quot[30:0], ge};
            r_low  <= {r_low[30:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_sat  = r_sat;

endmodule
`default_nettype wire

>>> hw/rtl/bbkg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbkg_datapath
// Bias state, configuration, shared multiplier, divider and result word.
// ----------------------------------------------------------------------------
module bbkg_datapath
    import bbkg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic        [31:0] i_cfg_wdata,
    input  logic signed [31:0] i_baro_altitude,
    input  logic               i_on_pad,
    input  logic               i_gps_lost,
    input  logic signed [31:0] i_down_position,
    input  logic        [31:0] i_down_position_var,
    output logic signed [31:0] o_corrected_altitude,
    output logic signed [31:0] o_innovation,
    output logic        [31:0] o_gate_ratio,
    output logic               o_rejected,
    output logic               o_zero_position,
    output logic signed [31:0] o_bias_out
);

    function automatic logic signed [67:0] rnd16(input logic signed [67:0] x);
        rnd16 = (x + 68'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647)
            sat32 = 32'sh7FFF_FFFF;
        else if (x < -68'sd2147483648)
            sat32 = 32'sh8000_0000;
        else
            sat32 = x[31:0];
    endfunction

    function automatic logic signed [67:0] sx68(input logic signed [31:0] x);
        sx68 = {{36{x[31]}}, x};
    endfunction

    logic        [31:0] r_noise;
    logic        [15:0] r_gate;
    logic signed [31:0] r_bias;
    logic        [31:0] r_var;

    logic signed [31:0] r_alt;
    logic               r_pad;
    logic               r_gps;
    logic signed [31:0] r_pd;
    logic        [31:0] r_pvar;
    logic signed [67:0] r_prod;
    logic signed [67:0] r_acc;
    logic signed [33:0] r_bi;
    logic        [32:0] r_s;
    logic        [16:0] r_k;
    logic signed [31:0] r_corr;
    logic signed [31:0] r_innov;
    logic        [62:0] r_sq;
    logic        [31:0] r_ratio;

    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    logic               mul_en;
    logic        [31:0] mag;
    logic        [32:0] gate_v;
    logic signed [67:0] nv;

    logic        div_start;
    logic [78:0] div_n;
    logic [64:0] div_d;
    logic        div_done;
    logic [31:0] div_q;
    logic        div_sat;

    assign mag    = r_innov[31] ? (~r_innov + 32'd1) : r_innov;
    assign gate_v = {1'b0, r_pvar} + {1'b0, r_noise};
    assign nv     = ((r_prod + 68'sd32768) >>> 16) + 68'(PROC_NOISE_Q);

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (i_cmd.op)
            OP_EMA_M1: begin
                mul_a = {{2{r_bias[31]}}, r_bias};
                mul_b = 34'(ONE_MINUS_ALPHA);
            end
            OP_EMA_M2: begin
                mul_a = {{2{r_alt[31]}}, r_alt};
                mul_b = 34'(ALPHA_Q);
            end
            OP_KF_MUL: begin
                mul_a = {17'b0, r_k};
                mul_b = r_bi;
            end
            OP_KF_BIAS: begin
                mul_a = {17'b0, 17'(Q_ONE) - r_k};
                mul_b = {2'b0, r_var};
            end
            OP_G_SQ: begin
                mul_a = {2'b0, mag};
                mul_b = {2'b0, mag};
            end
            OP_G_G2: begin
                mul_a = {18'b0, r_gate};
                mul_b = {18'b0, r_gate};
            end
            OP_G_D: begin
                mul_a = {2'b0, r_prod[31:0]};
                mul_b = {1'b0, gate_v};
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign div_start = (i_cmd.op == OP_K_START) || (i_cmd.op == OP_G_START);
    assign div_n = (i_cmd.op == OP_G_START) ? {r_sq, 16'b0} : {31'b0, r_var, 16'b0};
    assign div_d = (i_cmd.op == OP_G_START) ? r_prod[64:0] : {32'b0, r_s};

    bbkg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_sat      (div_sat)
    );

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= 32'(NOISE_RST);
            r_gate  <= 16'(GATE_RST);
            r_bias  <= '0;
            r_var   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_GATE)
                    r_gate <= i_cfg_wdata[15:0];
                else
                    r_noise <= i_cfg_wdata;
            end
            unique case (i_cmd.op)
                OP_PAD_INIT: begin
                    r_bias <= r_alt;
                    r_var  <= 32'(PAD_VAR_Q);
                end
                OP_EMA_RND: r_bias <= sat32(rnd16(r_acc));
                OP_KF_BIAS: r_bias <= sat32(sx68(r_bias) + rnd16(r_prod));
                OP_KF_VAR:  r_var <= (nv > 68'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : nv[31:0];
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (mul_en)
            r_prod <= mul_p;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_alt   <= i_baro_altitude;
                r_pad   <= i_on_pad;
                r_gps   <= i_gps_lost;
                r_pd    <= i_down_position;
                r_pvar  <= i_down_position_var;
                r_ratio <= '0;
            end
            OP_EMA_M2:  r_acc <= r_prod;
            OP_EMA_ADD: r_acc <= r_acc + r_prod;
            OP_KF_PREP: begin
                r_bi <= {{2{r_alt[31]}}, r_alt} + {{2{r_pd[31]}}, r_pd}
                        - {{2{r_bias[31]}}, r_bias};
                r_s  <= {1'b0, r_var} + {1'b0, r_noise};
            end
            OP_K_ZERO: r_k <= '0;
            OP_K_WAIT: begin
                if (div_done)
                    r_k <= div_q[16:0];
            end
            OP_CORR:  r_corr <= sat32(sx68(r_alt) - sx68(r_bias));
            OP_INNOV: r_innov <= r_pad ? '0 : sat32(sx68(r_corr) + sx68(r_pd));
            OP_G_G2:  r_sq <= r_prod[62:0];
            OP_G_DZERO: r_ratio <= (r_sq != '0) ? 32'hFFFF_FFFF : 32'h0;
            OP_G_WAIT: begin
                if (div_done)
                    r_ratio <= div_sat ? 32'hFFFF_FFFF : div_q;
            end
            OP_OUT_LOAD: begin
                o_corrected_altitude <= r_corr;
                o_innovation         <= r_innov;
                o_gate_ratio         <= r_ratio;
                o_rejected           <= (r_ratio > 32'(Q_ONE));
                o_zero_position      <= r_pad;
                o_bias_out           <= r_bias;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.pad       = r_pad;
        o_stat.gps_rej   = r_gps;
        o_stat.bias_zero = (r_bias == '0);
        o_stat.s_zero    = (r_s == '0);
        o_stat.d_zero    = (r_prod[64:0] == '0);
        o_stat.div_done  = div_done;
    end

endmodule
`default_nettype wire

>>> hw/rtl/bbkg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbkg_ctrl
// Sequencer: steps the datapath through pad, Kalman and gate phases and
// owns the result word's valid.
// ----------------------------------------------------------------------------
module bbkg_ctrl
    import bbkg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_PAD_INIT, S_EMA_M1, S_EMA_M2, S_EMA_ADD, S_EMA_RND,
        S_KF_PREP, S_K_SEL, S_K_ZERO, S_K_START, S_K_WAIT, S_KF_MUL, S_KF_BIAS,
        S_KF_VAR, S_CORR, S_INNOV, S_G_SQ, S_G_G2, S_G_D, S_G_CHK, S_G_DZERO,
        S_G_START, S_G_WAIT, S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        unique case (r_state)
            S_IDLE:     o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_PAD_INIT: o_cmd.op = OP_PAD_INIT;
            S_EMA_M1:   o_cmd.op = OP_EMA_M1;
            S_EMA_M2:   o_cmd.op = OP_EMA_M2;
            S_EMA_ADD:  o_cmd.op = OP_EMA_ADD;
            S_EMA_RND:  o_cmd.op = OP_EMA_RND;
            S_KF_PREP:  o_cmd.op = OP_KF_PREP;
            S_K_ZERO:   o_cmd.op = OP_K_ZERO;
            S_K_START:  o_cmd.op = OP_K_START;
            S_K_WAIT:   o_cmd.op = OP_K_WAIT;
            S_KF_MUL:   o_cmd.op = OP_KF_MUL;
            S_KF_BIAS:  o_cmd.op = OP_KF_BIAS;
            S_KF_VAR:   o_cmd.op = OP_KF_VAR;
            S_CORR:     o_cmd.op = OP_CORR;
            S_INNOV:    o_cmd.op = OP_INNOV;
            S_G_SQ:     o_cmd.op = OP_G_SQ;
            S_G_G2:     o_cmd.op = OP_G_G2;
            S_G_D:      o_cmd.op = OP_G_D;
            S_G_DZERO:  o_cmd.op = OP_G_DZERO;
            S_G_START:  o_cmd.op = OP_G_START;
            S_G_WAIT:   o_cmd.op = OP_G_WAIT;
            S_FIN:      o_cmd.op = out_free ? OP_OUT_LOAD : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid)
                        r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    priority if (i_stat.pad)
                        r_state <= i_stat.bias_zero ? S_PAD_INIT : S_EMA_M1;
                    else if (i_stat.gps_rej)
                        r_state <= S_CORR;
                    else
                        r_state <= S_KF_PREP;
                end
                S_PAD_INIT: r_state <= S_CORR;
                S_EMA_M1:   r_state <= S_EMA_M2;
                S_EMA_M2:   r_state <= S_EMA_ADD;
                S_EMA_ADD:  r_state <= S_EMA_RND;
                S_EMA_RND:  r_state <= S_CORR;
                S_KF_PREP:  r_state <= S_K_SEL;
                S_K_SEL:    r_state <= i_stat.s_zero ? S_K_ZERO : S_K_START;
                S_K_ZERO:   r_state <= S_KF_MUL;
                S_K_START:  r_state <= S_K_WAIT;
                S_K_WAIT: begin
                    if (i_stat.div_done)
                        r_state <= S_KF_MUL;
                end
                S_KF_MUL:   r_state <= S_KF_BIAS;
                S_KF_BIAS:  r_state <= S_KF_VAR;
                S_KF_VAR:   r_state <= S_CORR;
                S_CORR:     r_state <= S_INNOV;
                S_INNOV:    r_state <= i_stat.pad ? S_FIN : S_G_SQ;
                S_G_SQ:     r_state <= S_G_G2;
                S_G_G2:     r_state <= S_G_D;
                S_G_D:      r_state <= S_G_CHK;
                S_G_CHK:    r_state <= i_stat.d_zero ? S_G_DZERO : S_G_START;
                S_G_DZERO:  r_state <= S_FIN;
                S_G_START:  r_state <= S_G_WAIT;
                S_G_WAIT: begin
                    if (i_stat.div_done)
                        r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/baro_bias_kalman_gate_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baro_bias_kalman_gate_core
// Barometer bias estimator with chi-square innovation gate, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_ch takes one sample word (altitude, pad flag, GPS-lost flag, down
//   position and its variance); o_out_ch gives one result word per sample.
//   Configuration (noise variance, gate sigma) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_wdata while no sample is in flight.
//   Each 32-step serial division (Kalman gain, gate ratio) runs on the
//   shared restoring divider; a shared multiplier handles the products one
//   per cycle. One sample is processed at a time; the next is taken in the
//   cycle after the result is written.
//   The result word sits in an output register: the next sample is taken
//   while a result waits; a stalled receiver holds the block only when the
//   following result is ready to be written.
//   Reset clears the bias (uninitialized) and its variance and restores the
//   configuration defaults.
// ----------------------------------------------------------------------------
module baro_bias_kalman_gate_core
    import bbkg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    bbkg_in_if.sink     i_in_ch,
    bbkg_out_if.source  o_out_ch
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;

    bbkg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bbkg_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_baro_altitude      (i_in_ch.baro_altitude),
        .i_on_pad             (i_in_ch.on_pad),
        .i_gps_lost           (i_in_ch.gps_lost),
        .i_down_position      (i_in_ch.down_position),
        .i_down_position_var  (i_in_ch.down_position_var),
        .o_corrected_altitude (o_out_ch.corrected_altitude),
        .o_innovation         (o_out_ch.innovation),
        .o_gate_ratio         (o_out_ch.gate_ratio),
        .o_rejected           (o_out_ch.rejected),
        .o_zero_position      (o_out_ch.zero_position),
        .o_bias_out           (o_out_ch.bias_out)
    );

    assign i_in_ch.ready  = in_ready;
    assign o_out_ch.valid = out_valid;

`ifndef SYNTHESIS
    // one sample at a time: no second word right after an accepted one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ch.valid && i_in_ch.ready |=> !i_in_ch.ready)
        else $error("sample taken while previous one in flight");

    // pad words carry no gate result
    a_pad_no_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && o_out_ch.zero_position |->
            o_out_ch.innovation == 32'sd0 && o_out_ch.gate_ratio == 32'd0 &&
            !o_out_ch.rejected)
        else $error("gate result on pad word");

    a_reject_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && o_out_ch.rejected |-> o_out_ch.gate_ratio > 32'd65536)
        else $error("reject without ratio above one");
`endif

endmodule
`default_nettype wire
